// File: design/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// name, antecedent, consequent (same cycle)
`define ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("assertion failed");

// name, antecedent, consequent (next cycle)
`define ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/gf2ge_pkg.sv
`default_nettype none
package gf2ge_pkg;
    localparam int unsigned MAX_ROWS = 32;
    localparam int unsigned ROW_W    = 64;
    localparam int unsigned SYN_W    = 32;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned COL_W    = 7;

    typedef enum logic [3:0] {
        ST_LOAD   = 4'b0001,
        ST_FIND   = 4'b0010,
        ST_ELIM   = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    // broadcast from controller to every cell
    typedef struct packed {
        logic             load;
        logic [IDX_W-1:0] load_idx;
        logic             swap;
        logic [IDX_W-1:0] piv_idx;
        logic [IDX_W-1:0] hit_idx;
        logic             elim;
        logic [COL_W-1:0] col;
        logic             clr_syn;
    } cell_ctl_t;
endpackage
`default_nettype wire

// File: design/gf2ge_stream_if.sv
`default_nettype none
interface gf2ge_stream_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/gf2_gaussian_elimination_unit.sv
// Flow: after the last of M = min(N-K,32) rows, each column from K up, until column
//   N or M pivots, passes FIND and ELIM; ELIM swaps and then xors when the column
//   has a pivot. A closing FIND leads to OUT, which registers the result.
// Throughput: one row per cycle while loading, unless a result not yet taken stalls
//   the input; a new set is taken only after the last one reaches OUT.
// Reset: rst_n clears control state and the row count; row cells need none.
`default_nettype none
`include "assert_macros.svh"
module gf2_gaussian_elimination_unit
    import gf2ge_pkg::*;
#(
    parameter int unsigned CODE_LENGTH    = 64,
    parameter int unsigned CODE_DIMENSION = 32
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    gf2ge_stream_if.sink   in_ch,
    gf2ge_stream_if.source out_ch
);
    localparam int unsigned NN = (CODE_LENGTH > 64) ? 64 : CODE_LENGTH;
    localparam int unsigned MR = (CODE_DIMENSION >= NN) ? 0 :
        ((NN - CODE_DIMENSION > MAX_ROWS) ? MAX_ROWS : NN - CODE_DIMENSION);
    localparam int unsigned MC = (MR == 0) ? 1 : MR;

    state_t           st_reg, st_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [5:0]       piv_reg, piv_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    logic             found_reg, found_next;
    logic             ov_reg, ov_next;
    logic [SYN_W-1:0] osyn_reg, osyn_next;
    logic             ofr_reg, ofr_next;

    cell_ctl_t        ctl;
    logic [ROW_W-1:0] rows [MAX_ROWS];
    logic [MAX_ROWS-1:0] syns, cbits, diag;
    logic [ROW_W-1:0] piv_row, hit_row;
    logic             piv_syn, hit_syn;
    logic             fnd;
    logic [IDX_W-1:0] fidx;
    logic             accept;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (st_reg == ST_LOAD) && (!ov_reg || out_ch.ready);
    assign out_ch.valid = ov_reg;
    assign out_ch.data = {osyn_reg, ofr_reg};

    assign piv_row = rows[piv_reg[IDX_W-1:0]];
    assign piv_syn = syns[piv_reg[IDX_W-1:0]];
    assign hit_row = rows[hit_reg];
    assign hit_syn = syns[hit_reg];

    always_comb
    begin
        ctl = '0;
        ctl.load = accept && (MR != 0);
        ctl.load_idx = cnt_reg[IDX_W-1:0];
        ctl.piv_idx = piv_reg[IDX_W-1:0];
        ctl.hit_idx = hit_reg;
        ctl.col = col_reg;
        ctl.swap = (st_reg == ST_ELIM) && found_reg;
        ctl.elim = 1'b0;
        ctl.clr_syn = 1'b0;
    end

    // second elimination phase reuses ELIM: swap first, xor next cycle
    logic xor_phase_reg, xor_phase_next;
    cell_ctl_t ctl2;
    always_comb
    begin
        ctl2 = ctl;
        if (xor_phase_reg)
        begin
            ctl2.swap = 1'b0;
            ctl2.elim = 1'b1;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ROWS; g++)
        begin : g_cell
            gf2ge_cell #(.IDX(IDX_W'(g))) u_cell (
                .clk(clk), .ctl(ctl2),
                .load_row(in_ch.data[ROW_W:1]), .load_syn(in_ch.data[0]),
                .piv_row(piv_row), .piv_syn(piv_syn),
                .hit_row(hit_row), .hit_syn(hit_syn),
                .row_q(rows[g]), .syn_q(syns[g]), .col_bit(cbits[g])
            );
            assign diag[g] = (g >= MR) || (CODE_DIMENSION + g >= NN) ||
                rows[g][(CODE_DIMENSION + g) % 64];
        end
    endgenerate

    always_comb
    begin
        fnd = 1'b0;
        fidx = '0;
        for (int i = MAX_ROWS - 1; i >= 0; i--)
        begin
            if (cbits[i] && i < MR && i >= int'(piv_reg))
            begin
                fnd = 1'b1;
                fidx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        cnt_next = cnt_reg;
        piv_next = piv_reg;
        col_next = col_reg;
        hit_next = hit_reg;
        found_next = found_reg;
        xor_phase_next = 1'b0;
        ov_next = ov_reg && !out_ch.ready;
        osyn_next = osyn_reg;
        ofr_next = ofr_reg;
        unique case (st_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (MR == 0)
                    begin
                        ov_next = 1'b1;
                        osyn_next = '0;
                        ofr_next = 1'b1;
                    end
                    else if (cnt_reg == 6'(MR - 1))
                    begin
                        cnt_next = '0;
                        piv_next = '0;
                        col_next = COL_W'(CODE_DIMENSION);
                        st_next = ST_FIND;
                    end
                    else
                        cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_FIND:
            begin
                if (col_reg >= COL_W'(NN) || piv_reg >= 6'(MR))
                    st_next = ST_OUT;
                else
                begin
                    found_next = fnd;
                    hit_next = fidx;
                    st_next = ST_ELIM;
                end
            end
            ST_ELIM:
            begin
                if (!found_reg)
                begin
                    col_next = col_reg + COL_W'(1);
                    st_next = ST_FIND;
                end
                else if (!xor_phase_reg)
                    xor_phase_next = 1'b1;
                else
                begin
                    col_next = col_reg + COL_W'(1);
                    piv_next = piv_reg + 6'd1;
                    st_next = ST_FIND;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next = 1'b1;
                    for (int i = 0; i < SYN_W; i++)
                        osyn_next[i] = (i < MR) ? syns[i] : 1'b0;
                    ofr_next = &diag;
                    st_next = ST_LOAD;
                end
            end
            default: st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_LOAD;
            cnt_reg <= '0;
            piv_reg <= '0;
            col_reg <= '0;
            hit_reg <= '0;
            found_reg <= 1'b0;
            xor_phase_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            piv_reg <= piv_next;
            col_reg <= col_next;
            hit_reg <= hit_next;
            found_reg <= found_next;
            xor_phase_reg <= xor_phase_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osyn_reg <= osyn_next;
        ofr_reg <= ofr_next;
    end

    `ASSERT_IMP(a_ready_only_load, clk, rst_n, in_ch.ready, st_reg == ST_LOAD)
    `ASSERT_IMP(a_piv_bound, clk, rst_n, 1'b1, piv_reg <= 6'(MC))
    `ASSERT_NXT(a_out_after_elim, clk, rst_n,
        (st_reg == ST_OUT) && (!ov_reg || out_ch.ready), ov_reg)
    `ASSERT_IMP(a_xor_has_pivot, clk, rst_n, xor_phase_reg,
        found_reg && st_reg == ST_ELIM)
endmodule
`default_nettype wire

// File: design/gf2ge_cell.sv
`default_nettype none
// One matrix row with its syndrome bit. Rows are swapped and xored over shared
// pivot and hit buses that the unit muxes from all cells' rows.
module gf2ge_cell
    import gf2ge_pkg::*;
#(
    parameter logic [IDX_W-1:0] IDX = '0
)(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [ROW_W-1:0] load_row,
    input  wire logic             load_syn,
    input  wire logic [ROW_W-1:0] piv_row,
    input  wire logic             piv_syn,
    input  wire logic [ROW_W-1:0] hit_row,
    input  wire logic             hit_syn,
    output logic [ROW_W-1:0]      row_q,
    output logic                  syn_q,
    output logic                  col_bit
);
    logic [ROW_W-1:0] row_reg, row_next;
    logic             syn_reg, syn_next;

    assign col_bit = row_reg[ctl.col[5:0]];

    always_comb
    begin
        row_next = row_reg;
        syn_next = syn_reg;
        if (ctl.load && ctl.load_idx == IDX)
        begin
            row_next = load_row;
            syn_next = load_syn;
        end
        else if (ctl.swap)
        begin
            if (ctl.piv_idx == IDX)
            begin
                row_next = hit_row;
                syn_next = hit_syn;
            end
            else if (ctl.hit_idx == IDX)
            begin
                row_next = piv_row;
                syn_next = piv_syn;
            end
        end
        else if (ctl.elim && ctl.piv_idx != IDX && col_bit)
        begin
            row_next = row_reg ^ piv_row;
            syn_next = syn_reg ^ piv_syn;
        end
        if (ctl.clr_syn)
            syn_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
        syn_reg <= syn_next;
    end

    assign row_q = row_reg;
    assign syn_q = syn_reg;
endmodule
`default_nettype wire
